FILE: design/maxsc_pkg.sv
package maxsc_pkg;

    localparam int GRID_SIZE_DEF   = 16;
    localparam int FIELD_WIDTH_DEF = 32;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_INV_X     = 2'd1;
    localparam logic [1:0] CFG_INV_Y     = 2'd2;
    localparam logic [1:0] CFG_INV_Z     = 2'd3;

    localparam logic [31:0] TIME_STEP_RST = 32'd2147484;
    localparam logic [31:0] INV_CELL_RST  = 32'd8388608;

    // rounding shifts: curl term, half-step update, full-step update
    localparam logic [4:0] SH_TERM = 5'd17;
    localparam logic [4:0] SH_HALF = 5'd31;
    localparam logic [4:0] SH_FULL = 5'd30;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_CLEAR  = 4'd1;
    localparam logic [3:0] OP_LOAD   = 4'd2;
    localparam logic [3:0] OP_WRITE  = 4'd3;
    localparam logic [3:0] OP_READ   = 4'd4;
    localparam logic [3:0] OP_RES    = 4'd5;
    localparam logic [3:0] OP_NB_RD  = 4'd6;
    localparam logic [3:0] OP_TERM   = 4'd7;
    localparam logic [3:0] OP_CURL   = 4'd8;
    localparam logic [3:0] OP_UPD    = 4'd9;
    localparam logic [3:0] OP_DST_WR = 4'd10;
    localparam logic [3:0] OP_OUT    = 4'd11;

    // read slot holding the point itself (slots below are the six neighbors)
    localparam logic [2:0] SEL_CENTER = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         pos_x;
        logic [3:0]         pos_y;
        logic [3:0]         pos_z;
        logic signed [31:0] in_e_x;
        logic signed [31:0] in_e_y;
        logic signed [31:0] in_e_z;
        logic signed [31:0] in_b_x;
        logic signed [31:0] in_b_y;
        logic signed [31:0] in_b_z;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         done_kind;
        logic signed [31:0] out_e_x;
        logic signed [31:0] out_e_y;
        logic signed [31:0] out_e_z;
        logic signed [31:0] out_b_x;
        logic signed [31:0] out_b_y;
        logic signed [31:0] out_b_z;
    } out_word_t;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] sel;
        logic [1:0] sweep;
        logic       pt_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic pt_last;
    } dp_status_t;

endpackage

FILE: design/maxsc_mulsh.sv
module maxsc_mulsh
    import maxsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [31:0] b,
    input  logic [4:0]  sh,
    output logic        done,
    output logic [63:0] y
);

    // a * b / 2^sh, rounded half away from zero, saturated to 64 bits.
    // One 32x32 product per cycle; y is registered together with done.
    logic [3:0]  stg_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [63:0] mag_reg;
    logic [31:0] b_reg;
    logic [4:0]  sh_reg;
    logic [63:0] plo_reg;
    logic [63:0] phi_reg;
    logic [95:0] sum_reg;
    logic [63:0] y_reg;
    logic [95:0] shr;
    logic [63:0] y_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stg_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            stg_reg  <= {stg_reg[2:0], start};
            done_reg <= stg_reg[3];
        end
    end

    always_comb begin
        shr = sum_reg >> sh_reg;
        if (neg_reg) begin
            if (shr > {32'd0, 1'b1, 63'd0}) y_next = {1'b1, 63'd0};
            else                            y_next = ~shr[63:0] + 64'd1;
        end else begin
            if (shr[95:63] != '0) y_next = {1'b0, {63{1'b1}}};
            else                  y_next = shr[63:0];
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            neg_reg <= a[63];
            mag_reg <= a[63] ? (~a + 64'd1) : a;
            b_reg   <= b;
            sh_reg  <= sh;
        end
        if (stg_reg[0]) plo_reg <= {32'd0, mag_reg[31:0]} * {32'd0, b_reg};
        if (stg_reg[1]) phi_reg <= {32'd0, mag_reg[63:32]} * {32'd0, b_reg};
        if (stg_reg[2]) sum_reg <= {32'd0, plo_reg} + {phi_reg, 32'd0}
                                   + (96'd1 << (sh_reg - 5'd1));
        if (stg_reg[3]) y_reg <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

FILE: design/maxsc_dp.sv
module maxsc_dp
    import maxsc_pkg::*;
#(
    parameter int GRID_SIZE   = GRID_SIZE_DEF,
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  in_word_t   in_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_word_t  out_data
);

    localparam int FW    = FIELD_WIDTH;
    localparam int VW    = 3 * FW;
    localparam int CW    = $clog2(GRID_SIZE);
    localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] CMAX = CW'(GRID_SIZE - 1);
    localparam logic [AW-1:0] G_A  = AW'(GRID_SIZE);
    localparam logic signed [63:0] FW_HI = (64'sd1 <<< (FW - 1)) - 64'sd1;
    localparam logic signed [63:0] FW_LO = -FW_HI - 64'sd1;
    localparam logic signed [63:0] S32_HI = 64'sd2147483647;
    localparam logic signed [63:0] S32_LO = -64'sd2147483648;

    function automatic logic [63:0] sx(input logic [FW-1:0] v);
        return 64'(signed'(v));
    endfunction

    function automatic logic [FW-1:0] sat_fw(input logic [63:0] v);
        if (signed'(v) > FW_HI) return FW_HI[FW-1:0];
        if (signed'(v) < FW_LO) return FW_LO[FW-1:0];
        return v[FW-1:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [FW-1:0] v);
        logic [63:0] w;
        w = sx(v);
        if (signed'(w) > S32_HI) return S32_HI[31:0];
        if (signed'(w) < S32_LO) return S32_LO[31:0];
        return w[31:0];
    endfunction

    function automatic logic [63:0] sat65(input logic [64:0] s);
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [CW-1:0] wrap_pos(input logic [3:0] p);
        int v;
        v = int'(p);
        for (int i = 0; i < 4; i++) begin
            if (v >= GRID_SIZE) v = v - GRID_SIZE;
        end
        return CW'(v);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x,
                                             input logic [CW-1:0] y,
                                             input logic [CW-1:0] z);
        return AW'((AW'(z) * G_A + AW'(y)) * G_A + AW'(x));
    endfunction

    function automatic logic [CW-1:0] inc_c(input logic [CW-1:0] c);
        return (c == CMAX) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [CW-1:0] dec_c(input logic [CW-1:0] c);
        return (c == '0) ? CMAX : c - CW'(1);
    endfunction

    // configuration
    logic [31:0] ts_reg, icx_reg, icy_reg, icz_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ts_reg  <= TIME_STEP_RST;
            icx_reg <= INV_CELL_RST;
            icy_reg <= INV_CELL_RST;
            icz_reg <= INV_CELL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TIME_STEP: ts_reg  <= cfg_data;
                CFG_INV_X:     icx_reg <= cfg_data;
                CFG_INV_Y:     icy_reg <= cfg_data;
                CFG_INV_Z:     icz_reg <= cfg_data;
                default:       ts_reg  <= ts_reg;
            endcase
        end
    end

    // sweep point counter
    logic [CW-1:0] px_reg, py_reg, pz_reg;
    logic          pt_last;

    assign pt_last = (px_reg == CMAX) && (py_reg == CMAX) && (pz_reg == CMAX);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
        end else if (cmd.pt_inc) begin
            px_reg <= inc_c(px_reg);
            if (px_reg == CMAX) begin
                py_reg <= inc_c(py_reg);
                if (py_reg == CMAX) pz_reg <= inc_c(pz_reg);
            end
        end
    end

    // input word
    in_word_t in_reg;
    always_ff @(posedge clk) begin
        if (cmd.op == OP_LOAD) in_reg <= in_data;
    end

    logic [AW-1:0] in_addr, pt_addr, nb_addr;
    assign in_addr = addr_of(wrap_pos(in_reg.pos_x), wrap_pos(in_reg.pos_y),
                             wrap_pos(in_reg.pos_z));
    assign pt_addr = addr_of(px_reg, py_reg, pz_reg);

    always_comb begin
        case (cmd.sel)
            3'd0:    nb_addr = addr_of(inc_c(px_reg), py_reg, pz_reg);
            3'd1:    nb_addr = addr_of(dec_c(px_reg), py_reg, pz_reg);
            3'd2:    nb_addr = addr_of(px_reg, inc_c(py_reg), pz_reg);
            3'd3:    nb_addr = addr_of(px_reg, dec_c(py_reg), pz_reg);
            3'd4:    nb_addr = addr_of(px_reg, py_reg, inc_c(pz_reg));
            3'd5:    nb_addr = addr_of(px_reg, py_reg, dec_c(pz_reg));
            default: nb_addr = pt_addr;
        endcase
    end

    // field memories, components packed x in the low bits
    logic [VW-1:0] e_mem [DEPTH];
    logic [VW-1:0] b_mem [DEPTH];
    logic [VW-1:0] rd_e_reg, rd_b_reg;
    logic          e_we, b_we, e_re, b_re;
    logic [AW-1:0] wa, ra;
    logic [VW-1:0] e_wd, b_wd;
    logic          src_b, nb_slot, rd_from_b;
    logic [FW-1:0] new_reg [3];

    assign src_b     = (cmd.sweep == 2'd1);
    assign nb_slot   = (cmd.sel != SEL_CENTER);
    assign rd_from_b = nb_slot ? src_b : !src_b;

    always_comb begin
        e_we = 1'b0;
        b_we = 1'b0;
        e_re = 1'b0;
        b_re = 1'b0;
        wa   = pt_addr;
        ra   = nb_slot ? nb_addr : pt_addr;
        e_wd = '0;
        b_wd = '0;
        case (cmd.op)
            OP_CLEAR: begin
                e_we = 1'b1;
                b_we = 1'b1;
            end
            OP_WRITE: begin
                e_we = 1'b1;
                b_we = 1'b1;
                wa   = in_addr;
                e_wd = {sat_fw(64'(in_reg.in_e_z)), sat_fw(64'(in_reg.in_e_y)),
                        sat_fw(64'(in_reg.in_e_x))};
                b_wd = {sat_fw(64'(in_reg.in_b_z)), sat_fw(64'(in_reg.in_b_y)),
                        sat_fw(64'(in_reg.in_b_x))};
            end
            OP_READ: begin
                e_re = 1'b1;
                b_re = 1'b1;
                ra   = in_addr;
            end
            OP_NB_RD: begin
                e_re = !rd_from_b;
                b_re = rd_from_b;
            end
            OP_DST_WR: begin
                e_we = src_b;
                b_we = !src_b;
                e_wd = {new_reg[2], new_reg[1], new_reg[0]};
                b_wd = {new_reg[2], new_reg[1], new_reg[0]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk) begin
        if (e_we) e_mem[wa] <= e_wd;
        if (b_we) b_mem[wa] <= b_wd;
        if (e_re) rd_e_reg <= e_mem[ra];
        if (b_re) rd_b_reg <= b_mem[ra];
    end

    // neighbor capture, in the cycle after the read data is registered
    logic          cap_vld_reg;
    logic [2:0]    cap_idx_reg;
    logic          cap_b_reg;
    logic [VW-1:0] nb_reg [6];
    logic [VW-1:0] ctr_reg;
    logic [VW-1:0] cap_vec;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) cap_vld_reg <= 1'b0;
        else        cap_vld_reg <= (cmd.op == OP_NB_RD);
    end

    assign cap_vec = cap_b_reg ? rd_b_reg : rd_e_reg;

    always_ff @(posedge clk) begin
        if (cmd.op == OP_NB_RD) begin
            cap_idx_reg <= cmd.sel;
            cap_b_reg   <= rd_from_b;
        end
        if (cap_vld_reg) begin
            if (cap_idx_reg == SEL_CENTER) ctr_reg <= cap_vec;
            else                           nb_reg[cap_idx_reg] <= cap_vec;
        end
    end

    // operand selection for the shared multiplier
    logic [FW-1:0] op_p, op_m;
    logic [31:0]   op_ics;
    logic [63:0]   curl_reg [3];
    logic [63:0]   mul_a;
    logic [31:0]   mul_b;
    logic [4:0]    mul_sh;
    logic          mul_start, mul_done;
    logic [63:0]   mul_y;

    always_comb begin
        case (cmd.sel)
            3'd0: begin
                op_p = nb_reg[2][2*FW +: FW]; op_m = nb_reg[3][2*FW +: FW]; op_ics = icy_reg;
            end
            3'd1: begin
                op_p = nb_reg[4][FW +: FW];   op_m = nb_reg[5][FW +: FW];   op_ics = icz_reg;
            end
            3'd2: begin
                op_p = nb_reg[4][0 +: FW];    op_m = nb_reg[5][0 +: FW];    op_ics = icz_reg;
            end
            3'd3: begin
                op_p = nb_reg[0][2*FW +: FW]; op_m = nb_reg[1][2*FW +: FW]; op_ics = icx_reg;
            end
            3'd4: begin
                op_p = nb_reg[0][FW +: FW];   op_m = nb_reg[1][FW +: FW];   op_ics = icx_reg;
            end
            default: begin
                op_p = nb_reg[2][0 +: FW];    op_m = nb_reg[3][0 +: FW];    op_ics = icy_reg;
            end
        endcase
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = sx(op_p) - sx(op_m);
        mul_b     = op_ics;
        mul_sh    = SH_TERM;
        if (cmd.op == OP_TERM) begin
            mul_start = 1'b1;
        end else if (cmd.op == OP_UPD) begin
            mul_start = 1'b1;
            mul_b     = ts_reg;
            mul_sh    = src_b ? SH_FULL : SH_HALF;
            case (cmd.sel[1:0])
                2'd0:    mul_a = curl_reg[0];
                2'd1:    mul_a = curl_reg[1];
                default: mul_a = curl_reg[2];
            endcase
        end
    end

    maxsc_mulsh u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .done  (mul_done),
        .y     (mul_y)
    );

    // result routing
    logic        tag_upd_reg;
    logic [2:0]  tag_idx_reg;
    logic        sub_mode;
    logic [63:0] term_reg [6];
    logic [63:0] dst_old;
    logic [63:0] upd_sum;

    assign sub_mode = !src_b;

    always_comb begin
        case (tag_idx_reg[1:0])
            2'd0:    dst_old = sx(ctr_reg[0 +: FW]);
            2'd1:    dst_old = sx(ctr_reg[FW +: FW]);
            default: dst_old = sx(ctr_reg[2*FW +: FW]);
        endcase
        if (sub_mode) upd_sum = sat65({dst_old[63], dst_old} - {mul_y[63], mul_y});
        else          upd_sum = sat65({dst_old[63], dst_old} + {mul_y[63], mul_y});
    end

    always_ff @(posedge clk) begin
        if (mul_start) begin
            tag_upd_reg <= (cmd.op == OP_UPD);
            tag_idx_reg <= cmd.sel;
        end
        if (mul_done) begin
            if (tag_upd_reg) begin
                case (tag_idx_reg[1:0])
                    2'd0:    new_reg[0] <= sat_fw(upd_sum);
                    2'd1:    new_reg[1] <= sat_fw(upd_sum);
                    default: new_reg[2] <= sat_fw(upd_sum);
                endcase
            end else begin
                term_reg[tag_idx_reg] <= mul_y;
            end
        end
        if (cmd.op == OP_CURL) begin
            for (int c = 0; c < 3; c++) begin
                curl_reg[c] <= sat65({term_reg[2*c][63], term_reg[2*c]}
                                     - {term_reg[2*c+1][63], term_reg[2*c+1]});
            end
        end
    end

    // result word and output register
    out_word_t res_reg;
    out_word_t res_next;
    out_word_t out_reg;

    always_comb begin
        res_next           = '0;
        res_next.done_kind = in_reg.kind;
        if (in_reg.kind == KIND_READ) begin
            res_next.out_e_x = sat32(rd_e_reg[0 +: FW]);
            res_next.out_e_y = sat32(rd_e_reg[FW +: FW]);
            res_next.out_e_z = sat32(rd_e_reg[2*FW +: FW]);
            res_next.out_b_x = sat32(rd_b_reg[0 +: FW]);
            res_next.out_b_y = sat32(rd_b_reg[FW +: FW]);
            res_next.out_b_z = sat32(rd_b_reg[2*FW +: FW]);
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.op == OP_RES) res_reg <= res_next;
        if (cmd.op == OP_OUT) out_reg <= res_reg;
    end

    assign out_data        = out_reg;
    assign status.mul_done = mul_done;
    assign status.pt_last  = pt_last;

endmodule

FILE: design/maxsc_ctrl.sv
module maxsc_ctrl
    import maxsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_WRPT  = 4'd2;
    localparam logic [3:0] ST_RDPT  = 4'd3;
    localparam logic [3:0] ST_NB    = 4'd4;
    localparam logic [3:0] ST_NBW   = 4'd5;
    localparam logic [3:0] ST_TERM  = 4'd6;
    localparam logic [3:0] ST_TWAIT = 4'd7;
    localparam logic [3:0] ST_CURL  = 4'd8;
    localparam logic [3:0] ST_UPD   = 4'd9;
    localparam logic [3:0] ST_UWAIT = 4'd10;
    localparam logic [3:0] ST_DWR   = 4'd11;
    localparam logic [3:0] ST_RES   = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [2:0] sub_reg, sub_next;
    logic [1:0] sweep_reg, sweep_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            sub_reg   <= '0;
            sweep_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            sweep_reg <= sweep_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        sub_next   = sub_reg;
        sweep_next = sweep_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        cmd.sel    = sub_reg;
        cmd.sweep  = sweep_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op     = OP_CLEAR;
                cmd.pt_inc = 1'b1;
                if (status.pt_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op = OP_LOAD;
                    unique case (in_kind)
                        KIND_WRITE: state_next = ST_WRPT;
                        KIND_READ:  state_next = ST_RDPT;
                        KIND_STEP:  state_next = ST_NB;
                        default:    state_next = ST_RES;
                    endcase
                end
            end
            ST_WRPT: begin
                cmd.op     = OP_WRITE;
                state_next = ST_RES;
            end
            ST_RDPT: begin
                cmd.op     = OP_READ;
                state_next = ST_RES;
            end
            ST_NB: begin
                cmd.op = OP_NB_RD;
                if (sub_reg == SEL_CENTER) begin
                    sub_next   = '0;
                    state_next = ST_NBW;
                end else begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            ST_NBW: state_next = ST_TERM;
            ST_TERM: begin
                cmd.op     = OP_TERM;
                state_next = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (status.mul_done) begin
                    if (sub_reg == 3'd5) begin
                        sub_next   = '0;
                        state_next = ST_CURL;
                    end else begin
                        sub_next   = sub_reg + 3'd1;
                        state_next = ST_TERM;
                    end
                end
            end
            ST_CURL: begin
                cmd.op     = OP_CURL;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.op     = OP_UPD;
                state_next = ST_UWAIT;
            end
            ST_UWAIT: begin
                if (status.mul_done) begin
                    if (sub_reg == 3'd2) begin
                        sub_next   = '0;
                        state_next = ST_DWR;
                    end else begin
                        sub_next   = sub_reg + 3'd1;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_DWR: begin
                cmd.op     = OP_DST_WR;
                cmd.pt_inc = 1'b1;
                state_next = ST_NB;
                if (status.pt_last) begin
                    if (sweep_reg == 2'd2) begin
                        sweep_next = '0;
                        state_next = ST_RES;
                    end else begin
                        sweep_next = sweep_reg + 2'd1;
                    end
                end
            end
            ST_RES: begin
                cmd.op     = OP_RES;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!ov_reg || !out_stall) begin
                    cmd.op     = OP_OUT;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;

endmodule

FILE: design/maxwell_split_curl_update.sv
// channel | direction | handshake           | word
// cfg     | in        | cfg_we              | cfg_index, cfg_data (32 bits)
// in      | in        | in_valid / in_stall | in_word_t: kind, pos, E and B to write
// out     | out       | out_valid/out_stall | out_word_t: done_kind, E and B read
//
// After reset a clearing pass zeroes both field memories point by point,
// while in_stall stays high; configuration writes are taken throughout.
// Write and read words pass a load, an access and a result step before the
// output load; a step word makes three sweeps over all GRID_SIZE^3 points
// (per point: seven memory reads and one settle step, nine multiply-and-round
// passes on the one shared 64x32 multiplier, one curl step and one write-back step).
// One word is worked at a time; the next input word is taken while a finished
// result still waits in the output register under out_stall.
module maxwell_split_curl_update
    import maxsc_pkg::*;
#(
    parameter int GRID_SIZE   = GRID_SIZE_DEF,
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: clearing pass, item dispatch, per-point micro steps, sweeps
    maxsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (in_data.kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // field memories, neighbor registers, shared rounding multiplier
    maxsc_dp #(
        .GRID_SIZE   (GRID_SIZE),
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

FILE: design/maxsc_checker.sv
module maxsc_checker
    import maxsc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input out_word_t   out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("out word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken while one is in work");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_kind != KIND_READ |->
        out_data.out_e_x == 0 && out_data.out_e_y == 0 && out_data.out_e_z == 0 &&
        out_data.out_b_x == 0 && out_data.out_b_y == 0 && out_data.out_b_z == 0)
        else $error("non-read word carries field values");

endmodule

bind maxwell_split_curl_update maxsc_checker u_chk (.*);

FILE: tb/maxwell_split_curl_update_tb.sv
module maxwell_split_curl_update_tb;
    import maxsc_pkg::*;

    localparam int NPTS     = 4096;
    localparam int WD_LIMIT = 3000000;

    // Field store mirror and expected-result queue for the split curl update.
    class field_scoreboard;
        longint      fld[2][3][NPTS];   // [0] electric, [1] magnetic
        logic [31:0] dt_q30;
        logic [31:0] inv_cell[3];
        out_word_t   pending_q[$];
        int          errors;
        int          n_steps;
        int          n_checked;

        function new();
            foreach (fld[f, c, p]) fld[f][c][p] = 0;
            dt_q30 = TIME_STEP_RST;
            foreach (inv_cell[i]) inv_cell[i] = INV_CELL_RST;
            errors = 0;
            n_steps = 0;
            n_checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_TIME_STEP) dt_q30 = val;
            else if (idx == CFG_INV_X) inv_cell[0] = val;
            else if (idx == CFG_INV_Y) inv_cell[1] = val;
            else inv_cell[2] = val;
        endfunction

        static function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function longint add_sat(longint a, longint b);
            longint s;
            s = a + b;
            if (a > 0 && b > 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
            if (a < 0 && b < 0 && s >= 0) return 64'sh8000_0000_0000_0000;
            return s;
        endfunction

        static function longint sub_sat(longint a, longint b);
            longint s;
            s = a - b;
            if (a >= 0 && b < 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
            if (a < 0 && b > 0 && s >= 0) return 64'sh8000_0000_0000_0000;
            return s;
        endfunction

        // a*b / 2^sh, round half away from zero, saturate to 64 bits
        static function longint mul_round(longint a, logic [31:0] b, int sh);
            logic [63:0]  ua;
            logic [127:0] p;
            logic [127:0] r;
            bit           neg;
            neg = (a < 0);
            ua = a;
            if (neg) ua = ~ua + 64'd1;
            p = {64'd0, ua} * {96'd0, b} + (128'd1 << (sh - 1));
            r = p >> sh;
            if (!neg) begin
                if (r > 128'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
                return longint'(r[63:0]);
            end
            if (r > 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
            return -longint'(r[63:0]);
        endfunction

        static function int pt(int x, int y, int z);
            return (((z & 15) * 16 + (y & 15)) * 16) + (x & 15);
        endfunction

        function longint dterm(int f, int c, int ip, int im, int axis);
            return mul_round(fld[f][c][ip] - fld[f][c][im], inv_cell[axis], SH_TERM);
        endfunction

        // dst field moves by curl of the other field; B subtracts, E adds
        function void sweep(int dst, int sh);
            int     s;
            int     p;
            longint cu[3];
            longint u;
            s = 1 - dst;
            for (int z = 0; z < 16; z++)
                for (int y = 0; y < 16; y++)
                    for (int x = 0; x < 16; x++)
                    begin
                        p = pt(x, y, z);
                        cu[0] = sub_sat(dterm(s, 2, pt(x, y + 1, z), pt(x, y - 1, z), 1),
                                        dterm(s, 1, pt(x, y, z + 1), pt(x, y, z - 1), 2));
                        cu[1] = sub_sat(dterm(s, 0, pt(x, y, z + 1), pt(x, y, z - 1), 2),
                                        dterm(s, 2, pt(x + 1, y, z), pt(x - 1, y, z), 0));
                        cu[2] = sub_sat(dterm(s, 1, pt(x + 1, y, z), pt(x - 1, y, z), 0),
                                        dterm(s, 0, pt(x, y + 1, z), pt(x, y - 1, z), 1));
                        for (int c = 0; c < 3; c++)
                        begin
                            u = mul_round(cu[c], dt_q30, sh);
                            fld[dst][c][p] = clamp32(dst == 1 ? sub_sat(fld[dst][c][p], u)
                                                              : add_sat(fld[dst][c][p], u));
                        end
                    end
        endfunction

        function void note_input(in_word_t w);
            out_word_t e;
            int        p;
            e = '0;
            e.done_kind = w.kind;
            p = pt(w.pos_x, w.pos_y, w.pos_z);
            if (w.kind == KIND_WRITE)
            begin
                fld[0][0][p] = clamp32(longint'(w.in_e_x));
                fld[0][1][p] = clamp32(longint'(w.in_e_y));
                fld[0][2][p] = clamp32(longint'(w.in_e_z));
                fld[1][0][p] = clamp32(longint'(w.in_b_x));
                fld[1][1][p] = clamp32(longint'(w.in_b_y));
                fld[1][2][p] = clamp32(longint'(w.in_b_z));
            end
            else if (w.kind == KIND_STEP)
            begin
                sweep(1, SH_HALF);
                sweep(0, SH_FULL);
                sweep(1, SH_HALF);
                n_steps++;
            end
            else if (w.kind == KIND_READ)
            begin
                e.out_e_x = 32'(clamp32(fld[0][0][p]));
                e.out_e_y = 32'(clamp32(fld[0][1][p]));
                e.out_e_z = 32'(clamp32(fld[0][2][p]));
                e.out_b_x = 32'(clamp32(fld[1][0][p]));
                e.out_b_y = 32'(clamp32(fld[1][1][p]));
                e.out_b_z = 32'(clamp32(fld[1][2][p]));
            end
            pending_q.push_back(e);
        endfunction

        function void check(out_word_t got);
            out_word_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected output word %h", $time, got);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            n_checked++;
            if (got.done_kind !== e.done_kind)
                $display("%0t: done_kind exp %0d got %0d", $time, e.done_kind, got.done_kind);
            if (got.out_e_x !== e.out_e_x)
                $display("%0t: out_e_x exp %h got %h", $time, e.out_e_x, got.out_e_x);
            if (got.out_e_y !== e.out_e_y)
                $display("%0t: out_e_y exp %h got %h", $time, e.out_e_y, got.out_e_y);
            if (got.out_e_z !== e.out_e_z)
                $display("%0t: out_e_z exp %h got %h", $time, e.out_e_z, got.out_e_z);
            if (got.out_b_x !== e.out_b_x)
                $display("%0t: out_b_x exp %h got %h", $time, e.out_b_x, got.out_b_x);
            if (got.out_b_y !== e.out_b_y)
                $display("%0t: out_b_y exp %h got %h", $time, e.out_b_y, got.out_b_y);
            if (got.out_b_z !== e.out_b_z)
                $display("%0t: out_b_z exp %h got %h", $time, e.out_b_z, got.out_b_z);
            if (got !== e) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;

    field_scoreboard sb;
    int          idle_cycles;
    int          long_hold_done;
    int          written_pos[$];

    maxwell_split_curl_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Register write; mirrored in the predictor at once since no step word is in work.
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one word and hold it until taken. Valid stays up afterwards so
    // back-to-back words do not toggle it; gap_cycles lowers it.
    task automatic send_word(in_word_t w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input(w);
        if (w.kind == KIND_WRITE)
            written_pos.push_back(int'({w.pos_z, w.pos_y, w.pos_x}));
    endtask

    task automatic gap_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    function automatic in_word_t make_word(logic [1:0] k, int x, int y, int z,
                                           logic [31:0] v);
        in_word_t w;
        w = '0;
        w.kind  = k;
        w.pos_x = 4'(x);
        w.pos_y = 4'(y);
        w.pos_z = 4'(z);
        w.in_e_x = v;
        w.in_e_y = ~v;
        w.in_e_z = v ^ 32'h5A5A_5A5A;
        w.in_b_x = -v;
        w.in_b_y = v >>> 3;
        w.in_b_z = {v[15:0], v[31:16]};
        return w;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 65535) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // random word: mostly writes and reads, most reads at points written earlier
    function automatic in_word_t rand_word();
        in_word_t w;
        int       pick;
        int       r;
        r = $urandom_range(0, 99);
        w = make_word(KIND_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), rand_val());
        w.in_e_y = rand_val();
        w.in_b_z = rand_val();
        if (r < 45)
            w.kind = KIND_WRITE;
        else if (r < 94)
        begin
            w.kind = KIND_READ;
            if (written_pos.size() != 0 && $urandom_range(0, 2) != 0)
            begin
                pick = written_pos[$urandom_range(0, written_pos.size() - 1)];
                {w.pos_z, w.pos_y, w.pos_x} = pick[11:0];
            end
        end
        else
            w.kind = KIND_NONE;
        return w;
    endfunction

    // Receiver: its own stall pattern, plus one long hold-off mid-run so the
    // block fills its output register and pushes back on the input.
    initial
    begin
        int mode;
        int left;
        out_stall = 1'b0;
        long_hold_done = 0;
        mode = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && sb.n_checked >= 30)
            begin
                long_hold_done = 1;
                repeat (400)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(5, 60);
            end
            left--;
            case (mode)
                0:       out_stall <= 1'b0;                       // free flow
                1:       out_stall <= ($urandom_range(0, 1) == 1);
                default: out_stall <= ($urandom_range(0, 3) != 0); // mostly stalled
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_data);
    end

    // Watchdog: cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n_rand;
        sb = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_TIME_STEP;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Moderate setting while the clearing pass runs: dt 0.25, inverse cells 0.5, 1, 0.25.
        reg_write(CFG_TIME_STEP, 32'h1000_0000);
        reg_write(CFG_INV_X, 32'h0001_0000);
        reg_write(CFG_INV_Y, 32'h0002_0000);
        reg_write(CFG_INV_Z, 32'h0000_8000);

        // Directed: extreme values at corners and neighbors, wrap-around,
        // unused kind, reads of untouched points, one step and its readback.
        send_word(make_word(KIND_READ, 0, 0, 0, 0));
        send_word(make_word(KIND_WRITE, 0, 0, 0, 32'h7FFF_FFFF));
        send_word(make_word(KIND_WRITE, 15, 15, 15, 32'h8000_0000));
        send_word(make_word(KIND_WRITE, 1, 0, 0, 32'hFFFF_FFFF));
        send_word(make_word(KIND_WRITE, 0, 15, 0, 32'h0001_0000));
        send_word(make_word(KIND_WRITE, 0, 0, 1, 32'hFFFF_0000));
        send_word(make_word(KIND_WRITE, 15, 0, 0, 32'h0000_0001));
        send_word(make_word(KIND_WRITE, 0, 0, 15, 32'h0000_0000));
        send_word(make_word(KIND_READ, 0, 0, 0, 32'hFFFF_FFFF));
        send_word(make_word(KIND_READ, 15, 15, 15, 0));
        send_word(make_word(KIND_READ, 1, 0, 0, 0));
        send_word(make_word(KIND_NONE, 7, 9, 3, 32'hFFFF_FFFF));
        send_word(make_word(KIND_READ, 8, 8, 8, 0));
        send_word(make_word(KIND_STEP, 15, 15, 15, 32'hFFFF_FFFF));
        send_word(make_word(KIND_READ, 0, 0, 0, 0));
        send_word(make_word(KIND_READ, 15, 0, 0, 0));
        send_word(make_word(KIND_READ, 0, 15, 0, 0));
        send_word(make_word(KIND_READ, 0, 0, 15, 0));
        send_word(make_word(KIND_READ, 1, 1, 1, 0));
        send_word(make_word(KIND_READ, 15, 15, 15, 0));
        gap_cycles(1);
        drain();

        // Extreme setting for the random part: largest dt and inverse x cell,
        // zero inverse y cell, smallest nonzero inverse z cell.
        reg_write(CFG_TIME_STEP, 32'hFFFF_FFFF);
        reg_write(CFG_INV_X, 32'hFFFF_FFFF);
        reg_write(CFG_INV_Y, 32'h0000_0000);
        reg_write(CFG_INV_Z, 32'h0000_0001);

        n_rand = 0;
        while (n_rand < 100)
        begin
            int burst;
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if (n_rand == 50)
                    send_word(make_word(KIND_STEP, $urandom_range(0, 15), 0, 0, $urandom));
                else
                    send_word(rand_word());
                n_rand++;
            end
            if (n_rand >= 70 && n_rand - burst < 70)
            begin
                // sender pause until every expected word has come back
                gap_cycles(1);
                drain();
            end
            if ($urandom_range(0, 3) != 0)
                gap_cycles($urandom_range(1, 6));
        end
        gap_cycles(1);
        drain();
        repeat (50) @(posedge clk);

        $display("covered %0d split steps and %0d checked words over two register settings",
                 sb.n_steps, sb.n_checked);
        $display("writes, reads, unused kind, wrap-around neighbors and saturation at extremes");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
